>>> hdl/stae_pkg.sv
// ----------------------------------------------------------------------------
// stae_pkg
// Shared types, codes and the sine table generator for the tone generator.
// ----------------------------------------------------------------------------
`default_nettype none

package stae_pkg;

    // Item operation codes
    localparam logic [1:0] OP_TICK     = 2'd0;
    localparam logic [1:0] OP_NOTE_ON  = 2'd1;
    localparam logic [1:0] OP_NOTE_OFF = 2'd2;

    // Envelope stage codes
    localparam logic [1:0] ST_SILENT  = 2'd0;
    localparam logic [1:0] ST_ATTACK  = 2'd1;
    localparam logic [1:0] ST_SUSTAIN = 2'd2;
    localparam logic [1:0] ST_RELEASE = 2'd3;

    // Configuration register indexes
    localparam logic [1:0] CFG_OCTAVE     = 2'd0;
    localparam logic [1:0] CFG_ENV_LENGTH = 2'd1;
    localparam logic [1:0] CFG_ENV_STEP   = 2'd2;

    localparam int unsigned STEP_W   = 32;
    localparam int unsigned OCT_W    = 3;
    localparam int unsigned LEN_W    = 16;
    localparam int unsigned VOL_W    = 17;
    localparam int unsigned SAMPLE_W = 16;
    localparam int unsigned MAG_W    = 15;

    localparam logic [VOL_W-1:0] FULL_VOLUME   = 17'd65536;
    localparam logic [OCT_W-1:0] OCTAVE_UNITY  = 3'd3;
    localparam logic [LEN_W-1:0] ENV_LEN_RST   = 16'd960;
    localparam logic [VOL_W-1:0] ENV_STEP_RST  = 17'd68;

    typedef struct packed {
        logic [1:0]        operation;
        logic [STEP_W-1:0] phase_step;
    } t_in_item;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sample;
        logic                       sounding;
        logic [1:0]                 envelope_stage;
    } t_out_item;

    // Qualified envelope commands, one at most per cycle
    typedef struct packed {
        logic tick;
        logic note_on;
        logic note_off;
    } t_env_cmd;

    // Envelope as it stands after the current command
    typedef struct packed {
        logic [1:0]       stage;
        logic [VOL_W-1:0] volume;
    } t_env_view;

    // Quarter-wave magnitude for a position xr of a quarter of 2^(tbits-2)
    // steps; evaluated at elaboration only.
    function automatic logic [MAG_W-1:0] sine_mag(input longint unsigned xr,
                                                 input int unsigned tbits);
        longint unsigned one_q30;
        longint unsigned x;
        longint unsigned theta;
        longint unsigned t2;
        longint unsigned a;
        longint unsigned b;
        longint unsigned c;
        longint unsigned d;
        longint unsigned s;
        longint unsigned m;
        one_q30 = 64'd1 << 30;
        x       = xr << (32 - tbits);
        theta   = (x * 64'd1686629713) >> 30;
        t2      = (theta * theta) >> 30;
        a       = one_q30 - t2 / 64'd72;
        b       = one_q30 - ((t2 * a) >> 30) / 64'd42;
        c       = one_q30 - ((t2 * b) >> 30) / 64'd20;
        d       = one_q30 - ((t2 * c) >> 30) / 64'd6;
        s       = (theta * d) >> 30;
        m       = (s * 64'd32767 + (64'd1 << 29)) >> 30;
        if (m > 64'd32767) begin
            m = 64'd32767;
        end
        return m[MAG_W-1:0];
    endfunction

endpackage

`default_nettype wire

>>> hdl/sine_tone_with_ar_envelope.sv
// ----------------------------------------------------------------------------
// sine_tone_with_ar_envelope
// Phase-accumulator sine tone with a linear attack/release volume envelope.
// ----------------------------------------------------------------------------
// Flow: a tick item is taken into the input register and, once the result
//   register is free, its sample is registered in the result register; an
//   output stall holds the item in the input register meanwhile.
// Throughput: one item per cycle while the output is not stalled; envelope,
//   table read and one multiply run between the input and result registers.
// Reset: synchronous, active low; envelope silent, phase and step cleared,
//   octave 3, envelope length 960, envelope step 68.
`default_nettype none

module sine_tone_with_ar_envelope
    import stae_pkg::*;
#(
    parameter int unsigned SINE_TABLE_BITS = 10,
    parameter int unsigned PHASE_BITS      = 32
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_in_valid,
    output logic                  o_in_stall,
    input  wire t_in_item         i_in_item,
    output logic                  o_out_valid,
    input  wire logic             i_out_stall,
    output t_out_item             o_out_item,
    input  wire logic             i_cfg_valid,
    output logic                  o_cfg_ready,
    input  wire logic [1:0]       i_cfg_index,
    input  wire logic [VOL_W-1:0] i_cfg_data
);

    localparam int unsigned WIDE_W = (PHASE_BITS > STEP_W + 4) ? PHASE_BITS : STEP_W + 4;
    localparam int unsigned PROD_W = VOL_W + 1 + SAMPLE_W;

    // configuration registers
    logic [OCT_W-1:0] r_octave;
    logic [LEN_W-1:0] r_env_length;
    logic [VOL_W-1:0] r_env_step;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_octave     <= OCTAVE_UNITY;
            r_env_length <= ENV_LEN_RST;
            r_env_step   <= ENV_STEP_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_OCTAVE:     r_octave     <= i_cfg_data[OCT_W-1:0];
                CFG_ENV_LENGTH: r_env_length <= i_cfg_data[LEN_W-1:0];
                CFG_ENV_STEP:   r_env_step   <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // input register and flow control
    logic     r_in_valid;
    t_in_item r_in_item;
    logic     r_out_valid;
    t_out_item r_out_item;
    logic     out_free;
    logic     proc_go;
    logic     in_take;
    logic     is_tick;

    assign out_free   = !r_out_valid || !i_out_stall;
    assign proc_go    = r_in_valid && out_free;
    assign o_in_stall = r_in_valid && !out_free;
    assign in_take    = i_in_valid && !o_in_stall;
    assign is_tick    = r_in_item.operation == OP_TICK;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!r_in_valid || proc_go) begin
            r_in_valid <= in_take;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in_item <= i_in_item;
        end
    end

    // envelope
    t_env_cmd  env_cmd;
    t_env_view env;

    assign env_cmd.tick     = proc_go && is_tick;
    assign env_cmd.note_on  = proc_go && (r_in_item.operation == OP_NOTE_ON);
    assign env_cmd.note_off = proc_go && (r_in_item.operation == OP_NOTE_OFF);

    stae_envelope u_envelope (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (env_cmd),
        .i_env_length (r_env_length),
        .i_env_step   (r_env_step),
        .o_env        (env)
    );

    // phase accumulator
    logic [PHASE_BITS-1:0] r_phase;
    logic [PHASE_BITS-1:0] r_active_step;
    logic [WIDE_W-1:0]     step_wide;
    logic [WIDE_W-1:0]     step_shifted;
    logic                  sounding;

    assign step_wide    = WIDE_W'(r_in_item.phase_step);
    assign step_shifted = (r_octave >= OCTAVE_UNITY) ? step_wide << (r_octave - OCTAVE_UNITY)
                                                     : step_wide >> (OCTAVE_UNITY - r_octave);
    assign sounding     = env.stage != ST_SILENT;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase       <= '0;
            r_active_step <= '0;
        end else if (env_cmd.note_on) begin
            r_phase       <= '0;
            r_active_step <= step_shifted[PHASE_BITS-1:0];
        end else if (env_cmd.tick && sounding) begin
            r_phase <= r_phase + r_active_step;
        end
    end

    // sample: floor(volume * sine / 65536)
    logic signed [SAMPLE_W-1:0] sine_val;
    logic signed [PROD_W-1:0]   product;
    logic signed [SAMPLE_W-1:0] sample;

    stae_sine_lookup #(
        .TABLE_BITS (SINE_TABLE_BITS)
    ) u_sine (
        .i_index (r_phase[PHASE_BITS-1 -: SINE_TABLE_BITS]),
        .o_value (sine_val)
    );

    assign product = $signed({1'b0, env.volume}) * sine_val;
    assign sample  = sounding ? product[SAMPLE_W+15:16] : '0;

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= env_cmd.tick;
        end
    end

    always_ff @(posedge i_clk) begin
        if (env_cmd.tick) begin
            r_out_item.sample         <= sample;
            r_out_item.sounding       <= sounding;
            r_out_item.envelope_stage <= env.stage;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

endmodule

`default_nettype wire

>>> hdl/stae_envelope.sv
// ----------------------------------------------------------------------------
// stae_envelope
// Linear attack / release envelope state: stage, sample count and volume.
// ----------------------------------------------------------------------------
`default_nettype none

module stae_envelope
    import stae_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire t_env_cmd         i_cmd,
    input  wire logic [LEN_W-1:0] i_env_length,
    input  wire logic [VOL_W-1:0] i_env_step,
    output t_env_view             o_env
);

    logic [1:0]       r_stage;
    logic [1:0]       n_stage;
    logic [LEN_W-1:0] r_count;
    logic [LEN_W-1:0] n_count;
    logic [VOL_W-1:0] r_volume;
    logic [VOL_W-1:0] n_volume;
    logic [VOL_W:0]   vol_sum;

    assign vol_sum = {1'b0, r_volume} + {1'b0, i_env_step};

    always_comb begin
        n_stage  = r_stage;
        n_count  = r_count;
        n_volume = r_volume;
        if (i_cmd.note_on) begin
            n_stage  = ST_ATTACK;
            n_count  = i_env_length;
            n_volume = '0;
        end else if (i_cmd.note_off) begin
            // ignore note-off while silent
            if (r_stage != ST_SILENT) begin
                n_stage = ST_RELEASE;
                n_count = i_env_length;
            end
        end else if (i_cmd.tick) begin
            case (r_stage)
                ST_ATTACK: begin
                    if (r_count != '0) begin
                        n_volume = (vol_sum > {1'b0, FULL_VOLUME}) ? FULL_VOLUME
                                                                 : vol_sum[VOL_W-1:0];
                        n_count  = r_count - 1'b1;
                    end else begin
                        n_volume = FULL_VOLUME;
                        n_stage  = ST_SUSTAIN;
                    end
                end
                ST_RELEASE: begin
                    if (r_count != '0) begin
                        n_volume = (r_volume > i_env_step) ? r_volume - i_env_step : '0;
                        n_count  = r_count - 1'b1;
                    end else begin
                        n_volume = '0;
                        n_stage  = ST_SILENT;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stage  <= ST_SILENT;
            r_count  <= '0;
            r_volume <= '0;
        end else begin
            r_stage  <= n_stage;
            r_count  <= n_count;
            r_volume <= n_volume;
        end
    end

    assign o_env.stage  = n_stage;
    assign o_env.volume = n_volume;

endmodule

`default_nettype wire

>>> hdl/stae_sine_lookup.sv
// ----------------------------------------------------------------------------
// stae_sine_lookup
// Signed sine value from a quarter-wave constant table and quadrant folding.
// ----------------------------------------------------------------------------
`default_nettype none

module stae_sine_lookup
    import stae_pkg::*;
#(
    parameter int unsigned TABLE_BITS = 10
) (
    input  wire logic [TABLE_BITS-1:0]        i_index,
    output logic signed [SAMPLE_W-1:0]        o_value
);

    localparam int unsigned QB      = TABLE_BITS - 2;
    localparam int unsigned QUARTER = 2 ** QB;

    logic [MAG_W-1:0] qtab [0:QUARTER];

    for (genvar k = 0; k <= QUARTER; k++) begin : g_qtab
        localparam logic [MAG_W-1:0] MAG_K = sine_mag(longint'(k), TABLE_BITS);
        assign qtab[k] = MAG_K;
    end

    logic [1:0]     quad;
    logic [QB-1:0]  pos;
    logic [QB:0]    fold;
    logic [MAG_W-1:0] mag;

    assign quad = i_index[TABLE_BITS-1 -: 2];
    assign pos  = i_index[QB-1:0];
    // mirror the odd quadrants
    assign fold = quad[0] ? (QB+1)'(QUARTER) - {1'b0, pos} : {1'b0, pos};
    assign mag  = qtab[fold];

    assign o_value = quad[1] ? -$signed({1'b0, mag}) : $signed({1'b0, mag});

endmodule

`default_nettype wire
